// ===== rtl/bssl_pkg.sv =====
package bssl_pkg;

  localparam int LongW  = 16;
  localparam int CrcW   = 17;
  localparam int BlankW = 4;
  localparam int LaneW  = 3;
  localparam int RollW  = 4;

  localparam logic KIND_START  = 1'b0;
  localparam logic KIND_WINDOW = 1'b1;

  typedef enum logic [2:0] {
    CMD_SET_PHASES = 3'd0,
    CMD_MEASURE    = 3'd1,
    CMD_CLEAR      = 3'd2,
    CMD_BLANK      = 3'd3,
    CMD_LOCKED     = 3'd4,
    CMD_FAILED     = 3'd5
  } cmd_t;

  typedef enum logic [5:0] {
    MODE_IDLE    = 6'b000001,
    MODE_SWEEP   = 6'b000010,
    MODE_VERIFY1 = 6'b000100,
    MODE_VERIFY2 = 6'b001000,
    MODE_LOCKED  = 6'b010000,
    MODE_FAILED  = 6'b100000
  } mode_t;

  typedef enum logic [1:0] {
    REG_REROLL_LIMIT   = 2'd0,
    REG_LONG_THRESHOLD = 2'd1,
    REG_SETTLE_VALUE   = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [RollW-1:0]  reroll_limit;
    logic [LongW-1:0]  long_threshold;
    logic [BlankW-1:0] settle_value;
  } cfg_t;

  typedef struct packed {
    cmd_t              command;
    logic [LaneW-1:0]  lane0_phase;
    logic [LaneW-1:0]  lane1_phase;
    logic [BlankW-1:0] blank_value;
    logic [LongW-1:0]  min_long;
    logic [CrcW-1:0]   crc_total;
    logic              last;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    res0;
    result_t    res1;
  } push_t;

  function automatic result_t mk_result(cmd_t cmd, logic [LaneW-1:0] l0,
                                        logic [LaneW-1:0] l1,
                                        logic [BlankW-1:0] blank,
                                        logic [LongW-1:0] minl,
                                        logic [CrcW-1:0] crct, logic last);
    result_t r;
    r.command     = cmd;
    r.lane0_phase = l0;
    r.lane1_phase = l1;
    r.blank_value = blank;
    r.min_long    = minl;
    r.crc_total   = crct;
    r.last        = last;
    return r;
  endfunction

endpackage

// ===== rtl/bssl_core.sv =====
module bssl_core #(
  parameter int PHASES_PER_LANE = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        take,
  input  logic                        kind,
  input  logic [bssl_pkg::LongW-1:0]  long_count,
  input  logic [bssl_pkg::LongW-1:0]  short_count,
  input  logic [bssl_pkg::LongW-1:0]  crc_errors,
  input  bssl_pkg::cfg_t              cfg,
  output bssl_pkg::push_t             push
);

  localparam int LW = $clog2(PHASES_PER_LANE);
  localparam logic [LW-1:0] LastPhase = LW'(PHASES_PER_LANE - 1);
  localparam logic [bssl_pkg::LaneW-1:0] Zero3 = '0;

  bssl_pkg::mode_t mode, mode_next;
  logic [bssl_pkg::RollW-1:0] phase_count, phase_count_next;
  logic [LW-1:0] idx0, idx0_next, idx1, idx1_next;
  logic best_valid, best_valid_next;
  logic [bssl_pkg::LongW-1:0] best_long, best_long_next, best_short, best_short_next;
  logic [LW-1:0] best0, best0_next, best1, best1_next;
  logic [bssl_pkg::LongW-1:0] first_long, first_long_next, first_crc, first_crc_next;

  logic take_best;
  logic [LW-1:0] upd0, upd1;
  logic ok;
  logic [bssl_pkg::LongW-1:0] minl;
  logic [bssl_pkg::CrcW-1:0] crct;
  logic [bssl_pkg::LaneW-1:0] b0o, b1o;

  always_comb begin
    take_best = !best_valid || long_count > best_long ||
                (long_count == best_long && short_count > best_short);
    upd0 = take_best ? idx0 : best0;
    upd1 = take_best ? idx1 : best1;
    ok = first_long > cfg.long_threshold && long_count > cfg.long_threshold &&
         first_crc == '0 && crc_errors == '0;
    minl = (first_long < long_count) ? first_long : long_count;
    crct = {1'b0, first_crc} + {1'b0, crc_errors};
    b0o = bssl_pkg::LaneW'(best0);
    b1o = bssl_pkg::LaneW'(best1);
  end

  always_comb begin
    mode_next        = mode;
    phase_count_next = phase_count;
    idx0_next        = idx0;
    idx1_next        = idx1;
    best_valid_next  = best_valid;
    best_long_next   = best_long;
    best_short_next  = best_short;
    best0_next       = best0;
    best1_next       = best1;
    first_long_next  = first_long;
    first_crc_next   = first_crc;
    push             = '0;
    if (take) begin
      if (kind == bssl_pkg::KIND_START) begin
        phase_count_next = '0;
        first_long_next  = '0;
        first_crc_next   = '0;
        idx0_next        = '0;
        idx1_next        = '0;
        best_valid_next  = 1'b0;
        best_long_next   = '0;
        best_short_next  = '0;
        best0_next       = '0;
        best1_next       = '0;
        mode_next        = bssl_pkg::MODE_SWEEP;
        push.count = 2'd1;
        push.res0  = bssl_pkg::mk_result(bssl_pkg::CMD_SET_PHASES, Zero3, Zero3,
                                         '0, '0, '0, 1'b1);
      end else begin
        unique case (mode)
          bssl_pkg::MODE_SWEEP: begin
            if (take_best) begin
              best_valid_next = 1'b1;
              best_long_next  = long_count;
              best_short_next = short_count;
              best0_next      = idx0;
              best1_next      = idx1;
            end
            if (idx0 == LastPhase && idx1 == LastPhase) begin
              mode_next  = bssl_pkg::MODE_VERIFY1;
              push.count = 2'd2;
              push.res0  = bssl_pkg::mk_result(bssl_pkg::CMD_SET_PHASES,
                             bssl_pkg::LaneW'(upd0), bssl_pkg::LaneW'(upd1),
                             '0, '0, '0, 1'b0);
              push.res1  = bssl_pkg::mk_result(bssl_pkg::CMD_MEASURE,
                             bssl_pkg::LaneW'(upd0), bssl_pkg::LaneW'(upd1),
                             '0, '0, '0, 1'b1);
            end else begin
              if (idx1 == LastPhase) begin
                idx1_next = '0;
                idx0_next = idx0 + 1'b1;
              end else begin
                idx1_next = idx1 + 1'b1;
              end
              push.count = 2'd1;
              push.res0  = bssl_pkg::mk_result(bssl_pkg::CMD_SET_PHASES,
                             bssl_pkg::LaneW'(idx0_next), bssl_pkg::LaneW'(idx1_next),
                             '0, '0, '0, 1'b1);
            end
          end
          bssl_pkg::MODE_VERIFY1: begin
            first_long_next = long_count;
            first_crc_next  = crc_errors;
            mode_next       = bssl_pkg::MODE_VERIFY2;
            push.count = 2'd1;
            push.res0  = bssl_pkg::mk_result(bssl_pkg::CMD_MEASURE, b0o, b1o,
                                             '0, '0, '0, 1'b1);
          end
          bssl_pkg::MODE_VERIFY2: begin
            if (ok) begin
              mode_next  = bssl_pkg::MODE_LOCKED;
              push.count = 2'd2;
              push.res0  = bssl_pkg::mk_result(bssl_pkg::CMD_BLANK, b0o, b1o,
                                               cfg.settle_value, '0, '0, 1'b0);
              push.res1  = bssl_pkg::mk_result(bssl_pkg::CMD_LOCKED, b0o, b1o,
                                               '0, minl, crct, 1'b1);
            end else if (phase_count < cfg.reroll_limit) begin
              phase_count_next = phase_count + 1'b1;
              idx0_next        = '0;
              idx1_next        = '0;
              best_valid_next  = 1'b0;
              best_long_next   = '0;
              best_short_next  = '0;
              best0_next       = '0;
              best1_next       = '0;
              mode_next        = bssl_pkg::MODE_SWEEP;
              push.count = 2'd2;
              push.res0  = bssl_pkg::mk_result(bssl_pkg::CMD_CLEAR, Zero3, Zero3,
                                               '0, '0, '0, 1'b0);
              push.res1  = bssl_pkg::mk_result(bssl_pkg::CMD_SET_PHASES, Zero3, Zero3,
                                               '0, '0, '0, 1'b1);
            end else begin
              mode_next  = bssl_pkg::MODE_FAILED;
              push.count = 2'd1;
              push.res0  = bssl_pkg::mk_result(bssl_pkg::CMD_FAILED, b0o, b1o,
                                               '0, minl, crct, 1'b1);
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= bssl_pkg::MODE_IDLE;
      phase_count <= '0;
      idx0        <= '0;
      idx1        <= '0;
      best_valid  <= 1'b0;
      best_long   <= '0;
      best_short  <= '0;
      best0       <= '0;
      best1       <= '0;
      first_long  <= '0;
      first_crc   <= '0;
    end else begin
      mode        <= mode_next;
      phase_count <= phase_count_next;
      idx0        <= idx0_next;
      idx1        <= idx1_next;
      best_valid  <= best_valid_next;
      best_long   <= best_long_next;
      best_short  <= best_short_next;
      best0       <= best0_next;
      best1       <= best1_next;
      first_long  <= first_long_next;
      first_crc   <= first_crc_next;
    end
  end

endmodule

// ===== rtl/bssl_queue.sv =====
module bssl_queue (
  input  logic              clk,
  input  logic              rst,
  input  bssl_pkg::push_t   push,
  input  logic              pop,
  output logic              full,
  output logic              not_empty,
  output bssl_pkg::result_t head
);

  localparam int Depth = 4;
  localparam int PW = $clog2(Depth);

  bssl_pkg::result_t mem [Depth];
  logic [PW-1:0] wptr, rptr;
  logic [PW:0] count;
  logic [PW-1:0] wptr1;

  assign wptr1     = wptr + 1'b1;
  assign full      = count > (PW+1)'(Depth - 2);
  assign not_empty = count != '0;
  assign head      = mem[rptr];

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wptr] <= push.res0;
    end
    if (push.count == 2'd2) begin
      mem[wptr1] <= push.res1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + PW'(push.count);
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      count <= count + (PW+1)'(push.count) - (PW+1)'(pop);
    end
  end

endmodule

// ===== rtl/bitslip_sweep_lock_sequencer_unit.sv =====
// Bit-slip sweep lock sequencer, two lanes.
// An item's results enter the result queue as it is taken and are offered in order.
// Throughput: one item per cycle while the four-entry result queue holds two beats or
// fewer; results drain at one beat per cycle while result_stall is low.
// Reset (synchronous, rst high): mode idle, sweep state cleared, queue empty,
// registers back to reroll 8, threshold 3000, settle 14.
module bitslip_sweep_lock_sequencer_unit #(
  parameter int PHASES_PER_LANE = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic        kind,
  input  logic [15:0] long_count,
  input  logic [15:0] short_count,
  input  logic [15:0] crc_errors,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [2:0]  command,
  output logic [2:0]  lane0_phase,
  output logic [2:0]  lane1_phase,
  output logic [3:0]  blank_value,
  output logic [15:0] min_long,
  output logic [16:0] crc_total,
  output logic        last
);

  bssl_pkg::cfg_t    cfg;
  bssl_pkg::push_t   push;
  bssl_pkg::result_t head;
  logic full, take, pop;

  assign cfg_ready  = 1'b1;
  assign item_stall = full;
  assign take       = item_valid && !full;
  assign pop        = result_valid && !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.reroll_limit   <= 4'd8;
      cfg.long_threshold <= 16'd3000;
      cfg.settle_value   <= 4'd14;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        bssl_pkg::REG_REROLL_LIMIT:   cfg.reroll_limit   <= cfg_data[3:0];
        bssl_pkg::REG_LONG_THRESHOLD: cfg.long_threshold <= cfg_data;
        bssl_pkg::REG_SETTLE_VALUE:   cfg.settle_value   <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  bssl_core #(
    .PHASES_PER_LANE(PHASES_PER_LANE)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .kind        (kind),
    .long_count  (long_count),
    .short_count (short_count),
    .crc_errors  (crc_errors),
    .cfg         (cfg),
    .push        (push)
  );

  bssl_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .pop       (pop),
    .full      (full),
    .not_empty (result_valid),
    .head      (head)
  );

  assign command     = head.command;
  assign lane0_phase = head.lane0_phase;
  assign lane1_phase = head.lane1_phase;
  assign blank_value = head.blank_value;
  assign min_long    = head.min_long;
  assign crc_total   = head.crc_total;
  assign last        = head.last;

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  localparam int NPH          = 8;
  localparam int NPAIRS       = NPH * NPH;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int PHASE_BUDGET = 160;
  localparam int HOLD_AT      = 150;
  localparam int HOLD_LEN     = 160;
  localparam int CALM_FROM    = 600;
  localparam int CALM_TO      = 1400;
  localparam int IDLE_PCT     = 9;
  localparam int SETTLE_CYC   = 4;

  typedef struct packed {
    logic        kind;
    logic [15:0] long_cnt;
    logic [15:0] short_cnt;
    logic [15:0] crc_cnt;
  } window_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        item_valid = 1'b0;
  logic        item_stall;
  logic        kind = 1'b0;
  logic [15:0] long_count = '0;
  logic [15:0] short_count = '0;
  logic [15:0] crc_errors = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic [2:0]  command;
  logic [2:0]  lane0_phase;
  logic [2:0]  lane1_phase;
  logic [3:0]  blank_value;
  logic [15:0] min_long;
  logic [16:0] crc_total;
  logic        last;

  bitslip_sweep_lock_sequencer_unit #(.PHASES_PER_LANE(NPH)) DUT (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // register shadow
  logic [3:0]  rr_limit   = 4'd8;
  logic [15:0] thr        = 16'd3000;
  logic [3:0]  settle_val = 4'd14;

  // sequencer shadow
  bssl_pkg::mode_t seq_mode = bssl_pkg::MODE_IDLE;
  logic [3:0]  reroll_used = '0;
  logic [5:0]  sweep_pos   = '0;
  logic        best_seen   = 1'b0;
  logic [15:0] best_lc     = '0;
  logic [15:0] best_sc     = '0;
  logic [5:0]  best_idx    = '0;
  logic [15:0] win1_lc     = '0;
  logic [15:0] win1_ce     = '0;

  bssl_pkg::result_t expected_cmds[$];
  window_t pending_windows[$];
  int      cyc = 0;
  int      rx_count = 0;
  int      errors = 0;
  int      queued = 0;
  logic    item_took = 1'b0;
  logic    calm;

  assign calm = (cyc >= CALM_FROM) && (cyc < CALM_TO);

  task automatic add_cmd(bssl_pkg::cmd_t c, logic [5:0] pair, logic [3:0] blank,
                         logic [15:0] minl, logic [16:0] crct, logic fin);
    bssl_pkg::result_t r;
    r.command     = c;
    r.lane0_phase = 3'(pair / NPH);
    r.lane1_phase = 3'(pair % NPH);
    r.blank_value = blank;
    r.min_long    = minl;
    r.crc_total   = crct;
    r.last        = fin;
    expected_cmds.push_back(r);
  endtask

  task automatic clear_sweep();
    sweep_pos = '0;
    best_seen = 1'b0;
    best_lc   = '0;
    best_sc   = '0;
    best_idx  = '0;
    seq_mode  = bssl_pkg::MODE_SWEEP;
  endtask

  task automatic step_sequencer(window_t w);
    logic        lock_ok;
    logic [15:0] minl;
    logic [16:0] crct;
    if (w.kind == bssl_pkg::KIND_START) begin
      reroll_used = '0;
      win1_lc = '0;
      win1_ce = '0;
      clear_sweep();
      add_cmd(bssl_pkg::CMD_SET_PHASES, 6'd0, 4'd0, 16'd0, 17'd0, 1'b1);
    end else begin
      case (seq_mode)
        bssl_pkg::MODE_SWEEP: begin
          if (!best_seen || w.long_cnt > best_lc ||
              (w.long_cnt == best_lc && w.short_cnt > best_sc)) begin
            best_seen = 1'b1;
            best_lc   = w.long_cnt;
            best_sc   = w.short_cnt;
            best_idx  = sweep_pos;
          end
          if (int'(sweep_pos) + 1 < NPAIRS) begin
            sweep_pos++;
            add_cmd(bssl_pkg::CMD_SET_PHASES, sweep_pos, 4'd0, 16'd0, 17'd0, 1'b1);
          end else begin
            seq_mode = bssl_pkg::MODE_VERIFY1;
            add_cmd(bssl_pkg::CMD_SET_PHASES, best_idx, 4'd0, 16'd0, 17'd0, 1'b0);
            add_cmd(bssl_pkg::CMD_MEASURE, best_idx, 4'd0, 16'd0, 17'd0, 1'b1);
          end
        end
        bssl_pkg::MODE_VERIFY1: begin
          win1_lc  = w.long_cnt;
          win1_ce  = w.crc_cnt;
          seq_mode = bssl_pkg::MODE_VERIFY2;
          add_cmd(bssl_pkg::CMD_MEASURE, best_idx, 4'd0, 16'd0, 17'd0, 1'b1);
        end
        bssl_pkg::MODE_VERIFY2: begin
          lock_ok = win1_lc > thr && w.long_cnt > thr && win1_ce == 0 && w.crc_cnt == 0;
          minl = (win1_lc < w.long_cnt) ? win1_lc : w.long_cnt;
          crct = {1'b0, win1_ce} + {1'b0, w.crc_cnt};
          if (lock_ok) begin
            seq_mode = bssl_pkg::MODE_LOCKED;
            add_cmd(bssl_pkg::CMD_BLANK, best_idx, settle_val, 16'd0, 17'd0, 1'b0);
            add_cmd(bssl_pkg::CMD_LOCKED, best_idx, 4'd0, minl, crct, 1'b1);
          end else if (reroll_used < rr_limit) begin
            reroll_used++;
            clear_sweep();
            add_cmd(bssl_pkg::CMD_CLEAR, 6'd0, 4'd0, 16'd0, 17'd0, 1'b0);
            add_cmd(bssl_pkg::CMD_SET_PHASES, 6'd0, 4'd0, 16'd0, 17'd0, 1'b1);
          end else begin
            seq_mode = bssl_pkg::MODE_FAILED;
            add_cmd(bssl_pkg::CMD_FAILED, best_idx, 4'd0, minl, crct, 1'b1);
          end
        end
        default: ;
      endcase
    end
  endtask

  // input side: accept and predict
  always @(posedge clk) begin : take_p
    window_t seen;
    item_took = item_valid && !item_stall;
    if (!rst && item_took) begin
      seen = '{kind, long_count, short_count, crc_errors};
      step_sequencer(seen);
    end
  end

  always @(negedge clk) begin : send_p
    window_t nxt;
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!item_valid || item_took) begin
      if (pending_windows.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
        nxt = pending_windows.pop_front();
        item_valid  <= 1'b1;
        kind        <= nxt.kind;
        long_count  <= nxt.long_cnt;
        short_count <= nxt.short_cnt;
        crc_errors  <= nxt.crc_cnt;
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // output side: stall and check
  always @(negedge clk) begin
    rx_count++;
    if (rx_count >= HOLD_AT && rx_count < HOLD_AT + HOLD_LEN) begin
      result_stall <= 1'b1;
    end else if (calm) begin
      result_stall <= 1'b0;
    end else begin
      result_stall <= ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  always @(posedge clk) begin : check_p
    bssl_pkg::result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (expected_cmds.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected beat: cmd=%0d l0=%0d l1=%0d", command, lane0_phase,
                   lane1_phase);
      end else begin
        want = expected_cmds.pop_front();
        if (command !== want.command || lane0_phase !== want.lane0_phase ||
            lane1_phase !== want.lane1_phase || blank_value !== want.blank_value ||
            min_long !== want.min_long || crc_total !== want.crc_total ||
            last !== want.last) begin
          errors++;
          if (errors <= 10) begin
            $display("mismatch exp: cmd=%0d l0=%0d l1=%0d blank=%0d minl=%0d crc=%0d last=%0d",
                     want.command, want.lane0_phase, want.lane1_phase, want.blank_value,
                     want.min_long, want.crc_total, want.last);
            $display("         got: cmd=%0d l0=%0d l1=%0d blank=%0d minl=%0d crc=%0d last=%0d",
                     command, lane0_phase, lane1_phase, blank_value, min_long, crc_total,
                     last);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cyc++;
    if (cyc >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic write_reg(bssl_pkg::reg_idx_t idx, logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      bssl_pkg::REG_REROLL_LIMIT:   rr_limit   = val[3:0];
      bssl_pkg::REG_LONG_THRESHOLD: thr        = val;
      bssl_pkg::REG_SETTLE_VALUE:   settle_val = val[3:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(logic [3:0] rr, logic [15:0] th, logic [3:0] st);
    write_reg(bssl_pkg::REG_REROLL_LIMIT, {12'd0, rr});
    write_reg(bssl_pkg::REG_LONG_THRESHOLD, th);
    write_reg(bssl_pkg::REG_SETTLE_VALUE, {12'd0, st});
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_quiet();
    while (pending_windows.size() != 0 || item_valid || expected_cmds.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic push_window(logic k, logic [15:0] l, logic [15:0] s, logic [15:0] c);
    window_t w;
    w = '{k, l, s, c};
    pending_windows.push_back(w);
    queued++;
  endtask

  // 0: full range, 1: tiny values (ties), 2: extremes
  function automatic logic [15:0] sweep_val(int style);
    case (style)
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 3));
      default: begin
        case ($urandom_range(0, 3))
          0: return 16'h0000;
          1: return 16'h0001;
          2: return 16'hFFFE;
          default: return 16'hFFFF;
        endcase
      end
    endcase
  endfunction

  // one lock attempt sequence: start, sweeps, verification windows
  task automatic gen_run();
    int          style;
    int          tries;
    int          cut;
    logic        lock_ok;
    logic [15:0] l1, l2, c1, c2;
    style = $urandom_range(0, 2);
    push_window(bssl_pkg::KIND_START, 16'($urandom), 16'($urandom), 16'($urandom));
    for (tries = 0; tries <= int'(rr_limit); tries++) begin
      if ($urandom_range(0, 99) < 4) begin
        cut = $urandom_range(0, NPAIRS - 1);
        repeat (cut) push_window(bssl_pkg::KIND_WINDOW, sweep_val(style), sweep_val(style),
                                 16'($urandom));
        return;
      end
      repeat (NPAIRS) push_window(bssl_pkg::KIND_WINDOW, sweep_val(style), sweep_val(style),
                                  16'($urandom));
      lock_ok = (thr != 16'hFFFF) && ($urandom_range(0, 99) < 45);
      if (thr != 16'hFFFF) begin
        l1 = 16'($urandom_range(int'(thr) + 1, 65535));
        l2 = 16'($urandom_range(int'(thr) + 1, 65535));
      end else begin
        l1 = 16'($urandom);
        l2 = 16'($urandom);
      end
      c1 = '0;
      c2 = '0;
      if (!lock_ok) begin
        case ($urandom_range(0, 4))
          0: l1 = thr;
          1: l2 = 16'($urandom_range(0, int'(thr)));
          2: c1 = 16'($urandom_range(1, 65535));
          3: c2 = 16'($urandom_range(1, 65535));
          default: begin
            l1 = 16'($urandom);
            l2 = 16'($urandom);
            c1 = 16'($urandom);
            c2 = 16'($urandom);
          end
        endcase
      end
      push_window(bssl_pkg::KIND_WINDOW, l1, 16'($urandom), c1);
      push_window(bssl_pkg::KIND_WINDOW, l2, 16'($urandom), c2);
      if (lock_ok) break;
    end
    // windows after locked or failed are dropped
    repeat ($urandom_range(0, 2))
      push_window(bssl_pkg::KIND_WINDOW, 16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  initial begin
    int ph;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    push_window(bssl_pkg::KIND_WINDOW, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    push_window(bssl_pkg::KIND_WINDOW, 16'h0000, 16'h0000, 16'h0000);
    push_window(bssl_pkg::KIND_START, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    push_window(bssl_pkg::KIND_WINDOW, 16'h0000, 16'h0000, 16'h0000);
    push_window(bssl_pkg::KIND_WINDOW, 16'hFFFF, 16'h0000, 16'hFFFF);
    push_window(bssl_pkg::KIND_WINDOW, 16'hFFFF, 16'hFFFF, 16'h0000);
    push_window(bssl_pkg::KIND_WINDOW, 16'hFFFF, 16'hFFFF, 16'h0001);
    push_window(bssl_pkg::KIND_WINDOW, 16'hFFFE, 16'hFFFF, 16'h0000);
    push_window(bssl_pkg::KIND_START, 16'h0000, 16'h0000, 16'h0000);
    push_window(bssl_pkg::KIND_WINDOW, 16'h0001, 16'h0001, 16'h0000);

    queued = 0;
    while (queued < PHASE_BUDGET) gen_run();
    wait_quiet();

    for (ph = 1; ph < 6; ph++) begin
      case (ph)
        1: set_regs(4'd0, 16'd0, 4'd0);
        2: set_regs(4'd15, 16'd100, 4'd15);
        3: set_regs(4'd1, 16'hFFFF, 4'd5);
        default: set_regs(4'($urandom_range(0, 15)), 16'($urandom_range(0, 60000)),
                          4'($urandom_range(0, 15)));
      endcase
      queued = 0;
      while (queued < PHASE_BUDGET) gen_run();
      wait_quiet();
    end

    repeat (20) @(posedge clk);
    if (errors == 0 && expected_cmds.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
